@@ rtl/sec2cal_pkg.sv @@
`default_nettype none
package sec2cal_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_DST
  } state_t;

  // Division phases: seconds, minutes, hours, weekday
  typedef enum logic [1:0] {
    PH_SEC,
    PH_MIN,
    PH_HOUR,
    PH_WDAY
  } phase_t;

  localparam int unsigned IN_W       = 32;
  localparam int unsigned DAY_W      = 16;
  localparam int unsigned YOFF_W     = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // Reciprocals for dividends below 2^30: /15 takes the product from bit 34,
  // /3 from bit 32, /7 from bit 33
  localparam logic [30:0] RECIP_15 = 31'h4444_4445;
  localparam logic [30:0] RECIP_3  = 31'h5555_5556;
  localparam logic [30:0] RECIP_7  = 31'h4924_924A;

  localparam logic [11:0]        EPOCH_YEAR    = 12'd2000;
  localparam logic [3:0]         EPOCH_WEEKDAY = 4'd6;
  localparam logic [YOFF_W-1:0]  YOFF_2100     = 8'd100;
  localparam logic [DAY_W-1:0]   YEAR_LEN      = 16'd365;
  localparam logic [DAY_W-1:0]   LEAP_YEAR_LEN = 16'd366;
  localparam logic [DAY_W-1:0]   FEB_LAST_DAY  = 16'd58;
  localparam logic [5:0]         LAST_SUN_MIN  = 6'd25;
  localparam logic [3:0]         MONTH_MARCH   = 4'd3;
  localparam logic [3:0]         MONTH_OCTOBER = 4'd10;
  localparam logic [3:0]         MONTH_DEC     = 4'd12;
  localparam logic [4:0]         DST_HOUR      = 5'd2;
  localparam logic [4:0]         LAST_HOUR     = 5'd23;
  localparam logic [2:0]         SATURDAY      = 3'd6;

  // Month lengths, February counted as 29
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd1:    l = 5'd31;
      4'd2:    l = 5'd29;
      4'd3:    l = 5'd31;
      4'd4:    l = 5'd30;
      4'd5:    l = 5'd31;
      4'd6:    l = 5'd30;
      4'd7:    l = 5'd31;
      4'd8:    l = 5'd31;
      4'd9:    l = 5'd30;
      4'd10:   l = 5'd31;
      4'd11:   l = 5'd30;
      4'd12:   l = 5'd31;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

@@ rtl/seconds_to_calendar_dst.sv @@
// Sequencing: the seconds, minutes, hours and weekday divisions run on one shared reciprocal
//   multiplier, then the sequencer steps Y = whole years past 2000 (0..136) and M = months
//   (0..11), one year and one month per subtract/compare step.
// Handshake: in_tready is high only while the sequencer idles, so no new transaction is
//   taken while one is in progress, and a stalled result holds it busy.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle and drops out_tvalid.
`default_nettype none
module seconds_to_calendar_dst (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seconds_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [21:17] day_of_month, [25:22] month_of_year, [37:26] calendar_year,
  // [40:38] weekday, [47:41] zero
  output logic [47:0]      out_tdata,
  output logic             out_tuser   // [0] summer_time
);

  sec2cal_pkg::state_t state_r, state_nxt;
  sec2cal_pkg::phase_t ph_r, ph_nxt;

  logic [31:0] x_r, x_nxt;
  logic [31:0] q_r, q_nxt;
  logic        rem_step_r, rem_step_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [15:0] day_r, day_nxt;
  logic [7:0]  yoff_r, yoff_nxt;
  logic [3:0]  mon_r, mon_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;

  // Shared reciprocal multiplier
  logic [29:0] mul_a;
  logic [30:0] mul_b;
  logic [60:0] mul_p;
  logic [31:0] quo;
  logic [5:0]  rem60;
  logic [4:0]  rem24;
  logic [2:0]  rem7;

  // Shared subtract/compare unit
  logic [15:0] sub_a, sub_b;
  logic [16:0] sub_res;
  logic        sub_ge;

  logic        leap;
  logic [15:0] ylen;
  logic [4:0]  mlen;
  logic        month_step;
  logic        out_load;

  // Summer-time evaluation
  logic [4:0]  mday;
  logic        past_last_sun;
  logic        summer;
  logic        roll_day;
  logic [4:0]  fin_hour, fin_day;
  logic [3:0]  fin_mon;
  logic [2:0]  fin_wday;
  logic [11:0] fin_year;

  assign leap     = (yoff_r[1:0] == 2'b00) && (yoff_r != sec2cal_pkg::YOFF_2100);
  assign ylen     = leap ? sec2cal_pkg::LEAP_YEAR_LEN : sec2cal_pkg::YEAR_LEN;
  assign mlen     = sec2cal_pkg::month_len(mon_r);

  // Select dividend and reciprocal: /60 as /4 then /15, /24 as /8 then /3, /7 directly
  always_comb begin
    case (ph_r)
      sec2cal_pkg::PH_SEC, sec2cal_pkg::PH_MIN: begin
        mul_a = x_r[31:2];
        mul_b = sec2cal_pkg::RECIP_15;
      end
      sec2cal_pkg::PH_HOUR: begin
        mul_a = {1'b0, x_r[31:3]};
        mul_b = sec2cal_pkg::RECIP_3;
      end
      default: begin
        mul_a = x_r[29:0];
        mul_b = sec2cal_pkg::RECIP_7;
      end
    endcase
  end

  assign mul_p = {31'd0, mul_a} * {30'd0, mul_b};

  // Take the quotient from the product
  always_comb begin
    case (ph_r)
      sec2cal_pkg::PH_SEC, sec2cal_pkg::PH_MIN: quo = {5'd0, mul_p[60:34]};
      sec2cal_pkg::PH_HOUR:                     quo = {3'd0, mul_p[60:32]};
      default:                                  quo = {4'd0, mul_p[60:33]};
    endcase
  end

  // Remainders x - q*d, kept only to the bits the remainder needs
  assign rem60 = x_r[5:0] + {q_r[3:0], 2'b00};
  assign rem24 = x_r[4:0] + {q_r[1:0], 3'b000};
  assign rem7  = x_r[2:0] + q_r[2:0];

  // Select operands for the shared unit
  always_comb begin
    case (state_r)
      sec2cal_pkg::ST_YEAR: begin
        sub_a = day_r;
        sub_b = ylen;
      end
      sec2cal_pkg::ST_MONTH: begin
        sub_a = day_r;
        sub_b = {11'd0, mlen};
      end
      default: begin
        sub_a = day_r;
        sub_b = 16'd0;
      end
    endcase
  end

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge     = ~sub_res[16];
  assign month_step = (mon_r < sec2cal_pkg::MONTH_DEC) && sub_ge;

  // Evaluate EU summer time and roll the hour over
  assign mday          = day_r[4:0];
  assign past_last_sun = ({1'b0, mday} >= ({3'd0, wday_r} + sec2cal_pkg::LAST_SUN_MIN)) &&
                         ((wday_r != 3'd0) || (hour_r >= sec2cal_pkg::DST_HOUR));

  always_comb begin
    if ((mon_r < sec2cal_pkg::MONTH_MARCH) || (mon_r > sec2cal_pkg::MONTH_OCTOBER)) begin
      summer = 1'b0;
    end else if (past_last_sun) begin
      summer = (mon_r != sec2cal_pkg::MONTH_OCTOBER);
    end else begin
      summer = (mon_r != sec2cal_pkg::MONTH_MARCH);
    end
  end

  assign roll_day = summer && (hour_r == sec2cal_pkg::LAST_HOUR);
  assign fin_year = sec2cal_pkg::EPOCH_YEAR + {4'd0, yoff_r};

  always_comb begin
    fin_hour = hour_r;
    fin_day  = mday;
    fin_mon  = mon_r;
    fin_wday = wday_r;
    if (summer) begin
      fin_hour = roll_day ? 5'd0 : hour_r + 5'd1;
    end
    if (roll_day) begin
      fin_wday = (wday_r == sec2cal_pkg::SATURDAY) ? 3'd0 : wday_r + 3'd1;
      if (mday == mlen) begin
        fin_day = 5'd1;
        fin_mon = mon_r + 4'd1;
      end else begin
        fin_day = mday + 5'd1;
      end
    end
  end

  assign out_load = (state_r == sec2cal_pkg::ST_DST) && (!out_valid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sec2cal_pkg::ST_IDLE:  if (in_tvalid) state_nxt = sec2cal_pkg::ST_DIV;
      sec2cal_pkg::ST_DIV: begin
        if (rem_step_r && (ph_r == sec2cal_pkg::PH_WDAY)) state_nxt = sec2cal_pkg::ST_YEAR;
      end
      sec2cal_pkg::ST_YEAR:  if (!sub_ge) state_nxt = sec2cal_pkg::ST_MONTH;
      sec2cal_pkg::ST_MONTH: if (!month_step) state_nxt = sec2cal_pkg::ST_DST;
      sec2cal_pkg::ST_DST:   if (out_load) state_nxt = sec2cal_pkg::ST_IDLE;
      default:               state_nxt = sec2cal_pkg::ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    ph_nxt       = ph_r;
    x_nxt        = x_r;
    q_nxt        = q_r;
    rem_step_nxt = rem_step_r;
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    wday_nxt     = wday_r;
    day_nxt      = day_r;
    yoff_nxt     = yoff_r;
    mon_nxt      = mon_r;
    case (state_r)
      sec2cal_pkg::ST_IDLE: begin
        // Load the dividend for the first division
        x_nxt        = in_tdata;
        rem_step_nxt = 1'b0;
        ph_nxt       = sec2cal_pkg::PH_SEC;
      end
      sec2cal_pkg::ST_DIV: begin
        if (!rem_step_r) begin
          // Register the quotient of this phase
          q_nxt        = quo;
          rem_step_nxt = 1'b1;
        end else begin
          // Store the remainder and hand the quotient to the next phase
          rem_step_nxt = 1'b0;
          case (ph_r)
            sec2cal_pkg::PH_SEC: begin
              sec_nxt = rem60;
              x_nxt   = q_r;
              ph_nxt  = sec2cal_pkg::PH_MIN;
            end
            sec2cal_pkg::PH_MIN: begin
              min_nxt = rem60;
              x_nxt   = q_r;
              ph_nxt  = sec2cal_pkg::PH_HOUR;
            end
            sec2cal_pkg::PH_HOUR: begin
              hour_nxt = rem24;
              day_nxt  = q_r[15:0];
              x_nxt    = {16'd0, q_r[15:0] + {12'd0, sec2cal_pkg::EPOCH_WEEKDAY}};
              ph_nxt   = sec2cal_pkg::PH_WDAY;
            end
            default: begin
              wday_nxt = rem7;
              yoff_nxt = 8'd0;
            end
          endcase
        end
      end
      sec2cal_pkg::ST_YEAR: begin
        // Step whole years; on exit skip February 29 in common years
        mon_nxt = 4'd1;
        if (sub_ge) begin
          day_nxt  = sub_res[15:0];
          yoff_nxt = yoff_r + 8'd1;
        end else if (!leap && (day_r > sec2cal_pkg::FEB_LAST_DAY)) begin
          day_nxt = day_r + 16'd1;
        end
      end
      sec2cal_pkg::ST_MONTH: begin
        // Step whole months; on exit make the day one-based
        if (month_step) begin
          day_nxt = sub_res[15:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          day_nxt = day_r + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, fin_wday, fin_year, fin_mon, fin_day, fin_hour, min_r, sec_r};
      out_user_nxt  = summer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sec2cal_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    x_r        <= x_nxt;
    q_r        <= q_nxt;
    rem_step_r <= rem_step_nxt;
    sec_r      <= sec_nxt;
    min_r      <= min_nxt;
    hour_r     <= hour_nxt;
    wday_r     <= wday_nxt;
    day_r      <= day_nxt;
    yoff_r     <= yoff_nxt;
    mon_r      <= mon_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == sec2cal_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

@@ rtl/seconds_to_calendar_dst_chk.sv @@
`default_nettype none
module seconds_to_calendar_dst_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Stay busy after taking an input transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // Keep time fields in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] < 6'd60) && (out_tdata[11:6] < 6'd60) &&
                   (out_tdata[16:12] < 5'd24))
    else $error("time field out of range");

  // Flag summer time only between March and October
  a_summer_months: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[25:22] >= 4'd3) && (out_tdata[25:22] <= 4'd10))
    else $error("summer flag outside summer months");

endmodule

bind seconds_to_calendar_dst seconds_to_calendar_dst_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
